// File: rtl/segmented_memory_with_id_recycling_core_macros.svh
// ----------------------------------------------------------------------------
// Segmented memory core: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_MEMORY_WITH_ID_RECYCLING_CORE_MACROS_SVH
`define SEGMENTED_MEMORY_WITH_ID_RECYCLING_CORE_MACROS_SVH

// same-cycle implication
`define SMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sms_pkg.sv
// ----------------------------------------------------------------------------
// sms_pkg
// Item types, control structs and codes of the segmented memory core.
// ----------------------------------------------------------------------------
package sms_pkg;

   localparam int OP_W     = 3;
   localparam int SEG_ID_W = 6;
   localparam int OFF_W    = 10;
   localparam int WORD_W   = 32;
   localparam int LEN_W    = 11;
   localparam int STAT_W   = 3;

   localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
   localparam logic [OP_W-1:0] OP_STORE = 3'd1;
   localparam logic [OP_W-1:0] OP_MAP   = 3'd2;
   localparam logic [OP_W-1:0] OP_UNMAP = 3'd3;
   localparam logic [OP_W-1:0] OP_PROG  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STAT_W-1:0] STAT_UNMAPPED   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE      = 3'd2;
   localparam logic [STAT_W-1:0] STAT_UNMAP_ZERO = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NO_ID      = 3'd4;
   localparam logic [STAT_W-1:0] STAT_SIZE       = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]     opcode;
      logic [SEG_ID_W-1:0] segment_id;
      logic [OFF_W-1:0]    offset;
      logic [WORD_W-1:0]   word_in;
      logic [LEN_W-1:0]    map_size;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   word_out;
      logic [SEG_ID_W-1:0] new_segment_id;
      logic [STAT_W-1:0]   status;
   } rsp_type;

   // control -> id table
   typedef struct packed {
      logic             rd_en;
      logic             map_commit;
      logic             unmap_commit;
      logic             len0_wr;
      logic [LEN_W-1:0] len;
   } cmd_type;

   // id table -> control, valid the cycle after rd_en
   typedef struct packed {
      logic             mapped;
      logic             alloc_ok;
      logic             push_ok;
      logic [LEN_W-1:0] length;
   } info_type;

endpackage

// File: rtl/sms_word_ram.sv
// ----------------------------------------------------------------------------
// sms_word_ram
// Simple dual-port word memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sms_word_ram
   import sms_pkg::*;
#(
   parameter int DEPTH = 65536,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/sms_id_table.sv
// ----------------------------------------------------------------------------
// sms_id_table
// Segment bookkeeping: mapped bits, length memory, free-id stack and counters.
// ----------------------------------------------------------------------------
module sms_id_table
   import sms_pkg::*;
#(
   parameter int NUM_SEGMENTS = 64,
   localparam int ID_W = $clog2(NUM_SEGMENTS)
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  logic [ID_W-1:0] cmd_idx,
   output info_type        info,
   output logic [ID_W-1:0] alloc_id
);

   localparam int CNT_W = $clog2(NUM_SEGMENTS + 1);

   logic [NUM_SEGMENTS-1:0] mapped_ff, mapped_in;
   logic [LEN_W-1:0]        len0_ff, len0_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        fresh_ff, fresh_in;
   logic [ID_W-1:0]         idx_ff, idx_in;

   logic [LEN_W-1:0] len_mem [NUM_SEGMENTS];
   logic [LEN_W-1:0] len_rd_ff;
   logic [ID_W-1:0]  stack_mem [NUM_SEGMENTS];
   logic [ID_W-1:0]  stack_rd_ff;

   logic             count_nz;
   logic [CNT_W-1:0] count_dec;
   logic [ID_W-1:0]  stack_rd_addr;

   assign count_nz      = (count_ff != '0);
   assign count_dec     = count_ff - CNT_W'(1);
   assign stack_rd_addr = count_dec[ID_W-1:0];

   // recycled ids first, then fresh ones
   assign alloc_id      = count_nz ? stack_rd_ff : fresh_ff[ID_W-1:0];
   assign info.alloc_ok = count_nz || (fresh_ff < CNT_W'(NUM_SEGMENTS));
   assign info.push_ok  = (count_ff < CNT_W'(NUM_SEGMENTS));
   assign info.mapped   = mapped_ff[idx_ff];
   assign info.length   = (idx_ff == '0) ? len0_ff : len_rd_ff;

   always_comb begin
      mapped_in = mapped_ff;
      count_in  = count_ff;
      fresh_in  = fresh_ff;
      len0_in   = len0_ff;
      idx_in    = cmd.rd_en ? cmd_idx : idx_ff;
      if (cmd.map_commit) begin
         mapped_in[alloc_id] = 1'b1;
         if (count_nz) begin
            count_in = count_dec;
         end else begin
            fresh_in = fresh_ff + CNT_W'(1);
         end
      end
      if (cmd.unmap_commit) begin
         mapped_in[idx_ff] = 1'b0;
         count_in          = count_ff + CNT_W'(1);
      end
      if (cmd.len0_wr) begin
         len0_in = cmd.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff <= NUM_SEGMENTS'(1);
         count_ff  <= '0;
         fresh_ff  <= CNT_W'(1);
         len0_ff   <= '0;
      end else begin
         mapped_ff <= mapped_in;
         count_ff  <= count_in;
         fresh_ff  <= fresh_in;
         len0_ff   <= len0_in;
      end
      idx_ff <= idx_in;
   end

   // length memory; unmapped entries are never consulted
   always_ff @(posedge clock) begin
      if (cmd.map_commit) begin
         len_mem[alloc_id] <= cmd.len;
      end
      if (cmd.rd_en) begin
         len_rd_ff <= len_mem[cmd_idx];
      end
   end

   // free-id stack, top entry prefetched on every lookup
   always_ff @(posedge clock) begin
      if (cmd.unmap_commit) begin
         stack_mem[count_ff[ID_W-1:0]] <= idx_ff;
      end
      if (cmd.rd_en) begin
         stack_rd_ff <= stack_mem[stack_rd_addr];
      end
   end

`include "segmented_memory_with_id_recycling_core_macros.svh"

   `SMS_ASSERT_NOW(a_seg0_mapped, 1'b1, mapped_ff[0], "segment zero lost its mapping")
   `SMS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(NUM_SEGMENTS), "free count overflow")
   `SMS_ASSERT_NOW(a_map_alloc, cmd.map_commit, info.alloc_ok, "map committed with no free id")
   `SMS_ASSERT_NOW(a_unmap_push, cmd.unmap_commit, info.push_ok && (idx_ff != '0), "bad unmap push")

endmodule

// File: rtl/segmented_memory_with_id_recycling_core.sv
// ----------------------------------------------------------------------------
// segmented_memory_with_id_recycling_core
// Segmented word memory with id recycling: load, store, map, unmap, load program.
// ----------------------------------------------------------------------------
// Map zero-fills the new segment (zero-fill writes one word a cycle); load
// program copies the source segment into segment zero (one word copied a
// cycle through the word memory ports). One item in flight; the next is taken
// once the result is parked in the output register. Reset is synchronous and
// leaves segment zero mapped with length zero; there is no clearing pass.
module segmented_memory_with_id_recycling_core
   import sms_pkg::*;
#(
   parameter int NUM_SEGMENTS = 64,
   parameter int SEG_WORDS    = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_item,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   localparam int ID_W   = $clog2(NUM_SEGMENTS);
   localparam int DEPTH  = NUM_SEGMENTS * SEG_WORDS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int EXT_W  = ID_W + SEG_ID_W;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;   // waiting for an item
   localparam logic [2:0] S_LOOK = 3'd1;   // table data back, decide
   localparam logic [2:0] S_READ = 3'd2;   // load word returning
   localparam logic [2:0] S_FILL = 3'd3;   // zero-fill of a new segment
   localparam logic [2:0] S_COPY = 3'd4;   // program copy into segment zero
   localparam logic [2:0] S_DONE = 3'd5;   // hand result to output register

   logic [2:0]        state_ff, state_in;
   req_type           item_ff, item_in;
   logic              range_ff, range_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  wcnt_ff, wcnt_in;
   logic              pend_ff, pend_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // id table interface
   cmd_type         cmd;
   logic [ID_W-1:0] cmd_idx;
   info_type        info;
   logic [ID_W-1:0] alloc_id;

   // word memory interface
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   logic [EXT_W-1:0]  seg_ext;
   logic [ID_W-1:0]   req_idx;
   logic              req_in_range;
   logic [LEN_W-1:0]  csr_len;
   logic              seg_ok;
   logic              out_free;
   logic              copy_go;
   logic [EXT_W-1:0]  nid_ext;

   // segment ids above the table depth are rejected as unmapped
   assign seg_ext      = EXT_W'(req_item.segment_id);
   assign req_idx      = seg_ext[ID_W-1:0];
   assign req_in_range = (seg_ext < EXT_W'(NUM_SEGMENTS));

   // program length saturates at the slot size
   assign csr_len = (32'(csr_wr_data) > 32'(SEG_WORDS)) ? LEN_W'(SEG_WORDS) : csr_wr_data;

   assign seg_ok   = range_ff && info.mapped;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign copy_go  = (cnt_ff < len_ff);
   assign nid_ext  = EXT_W'(alloc_id);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      range_in  = range_ff;
      base_in   = base_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      wcnt_in   = cnt_ff;
      pend_in   = 1'b0;
      res_in    = res_ff;
      cmd       = '0;
      cmd_idx   = req_idx;
      ram_we    = 1'b0;
      ram_waddr = base_ff + ADDR_W'(cnt_ff);
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = base_ff + ADDR_W'(item_ff.offset);

      // csr writes land in the segment zero length register
      if (csr_wr_en) begin
         cmd.len0_wr = 1'b1;
         cmd.len     = csr_len;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.rd_en = 1'b1;
               item_in   = req_item;
               range_in  = req_in_range;
               base_in   = ADDR_W'(req_idx) * ADDR_W'(SEG_WORDS);
               res_in    = '0;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_DONE;
            unique case (item_ff.opcode) inside
               OP_LOAD, OP_STORE: begin
                  if (!seg_ok) begin
                     res_in.status = STAT_UNMAPPED;
                  end else if (LEN_W'(item_ff.offset) >= info.length) begin
                     res_in.status = STAT_RANGE;
                  end else if (item_ff.opcode == OP_LOAD) begin
                     ram_re   = 1'b1;
                     state_in = S_READ;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = base_ff + ADDR_W'(item_ff.offset);
                     ram_wdata = item_ff.word_in;
                  end
               end
               OP_MAP: begin
                  if (32'(item_ff.map_size) > 32'(SEG_WORDS)) begin
                     res_in.status = STAT_SIZE;
                  end else if (!info.alloc_ok) begin
                     res_in.status = STAT_NO_ID;
                  end else begin
                     cmd.map_commit        = 1'b1;
                     cmd.len               = item_ff.map_size;
                     res_in.new_segment_id = nid_ext[SEG_ID_W-1:0];
                     base_in               = ADDR_W'(alloc_id) * ADDR_W'(SEG_WORDS);
                     cnt_in                = '0;
                     len_in                = item_ff.map_size;
                     if (item_ff.map_size != '0) begin
                        state_in = S_FILL;
                     end
                  end
               end
               OP_UNMAP: begin
                  if (item_ff.segment_id == '0) begin
                     res_in.status = STAT_UNMAP_ZERO;
                  end else if (!seg_ok) begin
                     res_in.status = STAT_UNMAPPED;
                  end else if (info.push_ok) begin
                     cmd.unmap_commit = 1'b1;
                  end
               end
               OP_PROG: begin
                  if (!seg_ok) begin
                     res_in.status = STAT_UNMAPPED;
                  end else if (item_ff.segment_id != '0) begin
                     // new length takes effect now; segment zero is not read
                     // until the copy is over
                     cmd.len0_wr = 1'b1;
                     cmd.len     = info.length;
                     cnt_in      = '0;
                     len_in      = info.length;
                     if (info.length != '0) begin
                        state_in = S_COPY;
                     end
                  end
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         S_READ: begin
            res_in.word_out = ram_rdata;
            state_in        = S_DONE;
         end
         S_FILL: begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + LEN_W'(1);
            if (cnt_ff == len_ff - LEN_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_COPY: begin
            // read word n while word n-1 is written into segment zero
            ram_re    = copy_go;
            ram_raddr = base_ff + ADDR_W'(cnt_ff);
            pend_in   = copy_go;
            ram_we    = pend_ff;
            ram_waddr = ADDR_W'(wcnt_ff);
            ram_wdata = ram_rdata;
            if (copy_go) begin
               cnt_in = cnt_ff + LEN_W'(1);
            end else if (pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff  <= item_in;
      range_ff <= range_in;
      base_ff  <= base_in;
      cnt_ff   <= cnt_in;
      len_ff   <= len_in;
      wcnt_ff  <= wcnt_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   sms_id_table #(
      .NUM_SEGMENTS (NUM_SEGMENTS)
   ) u_id_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cmd_idx  (cmd_idx),
      .info     (info),
      .alloc_id (alloc_id)
   );

   sms_word_ram #(
      .DEPTH (DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

`include "segmented_memory_with_id_recycling_core_macros.svh"

   `SMS_ASSERT_NOW(a_fill_bound, state_ff == S_FILL, cnt_ff < len_ff, "fill ran past length")
   `SMS_ASSERT_NOW(a_idle_no_write, state_ff == S_IDLE, !ram_we, "word write while idle")
   `SMS_ASSERT_NEXT(a_result_parked, (state_ff == S_DONE) && out_free, rsp_valid_ff && (state_ff == S_IDLE), "result not parked")

endmodule

// File: tb/segmented_memory_with_id_recycling_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_memory_with_id_recycling_core_test
// Self-checking bench for the segmented memory core. A directed table covers
// error codes, opcode extremes and id recycling. Random phases then run under
// several program_length settings, each phase with one of three operation mixes.
// A shadow copy of the segment store predicts the result of every accepted item
// that a directed row does not type in, and each result is compared field by field, in order.
// ----------------------------------------------------------------------------
module segmented_memory_with_id_recycling_core_test;
   import sms_pkg::*;

   localparam int NSEG          = 64;
   localparam int SEGW          = 1024;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 315;
   localparam int MAX_NOTES     = 60;
   localparam int IDLE_PCT      = 38;

   // opcodes the core has no use for
   localparam logic [OP_W-1:0] OP_BAD_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

   typedef enum int {MIX_BALANCED, MIX_MAP_HEAVY, MIX_UNMAP_HEAVY} mix_type;

   // one directed row: the item, and the typed-in result where there is one
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type answer;
   } row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_item    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_item;
   logic             csr_wr_en   = 1'b0;
   logic [LEN_W-1:0] csr_wr_data = '0;

   // shadow copy of the core's state
   logic [WORD_W-1:0]   shadow_words [NSEG*SEGW];
   logic [LEN_W-1:0]    shadow_len   [NSEG];
   bit                  shadow_live  [NSEG];
   logic [SEG_ID_W-1:0] free_ids     [NSEG];
   int                  free_top;
   int                  fresh_id;
   // words of segment zero that hold defined data since reset or load program
   bit                  seg0_written [SEGW];

   rsp_type pending_rsp [$];
   row_type plan [$];
   int      failures = 0;
   bit      calm     = 1'b0;

   segmented_memory_with_id_recycling_core #(
      .NUM_SEGMENTS(NSEG),
      .SEG_WORDS   (SEGW)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow model
   // ---------------------------------------------------------------------
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
      return (v > SEGW) ? LEN_W'(SEGW) : v;
   endfunction

   function automatic void shadow_reset();
      int s;
      for (s = 0; s < NSEG; s++) begin
         shadow_len[s]  = '0;
         shadow_live[s] = 1'b0;
      end
      for (s = 0; s < SEGW; s++) seg0_written[s] = 1'b0;
      shadow_live[0] = 1'b1;
      free_top       = 0;
      fresh_id       = 1;
   endfunction

   // Applies one item to the shadow state and returns the result it yields.
   function automatic rsp_type apply_mem_op(input req_type r);
      rsp_type          o;
      int               id;
      int               base;
      int               n;
      int               seg;
      logic [LEN_W-1:0] copy_len;
      o   = '0;
      seg = int'(r.segment_id);
      case (r.opcode)
         OP_LOAD, OP_STORE: begin
            if (!shadow_live[seg])
               o.status = STAT_UNMAPPED;
            else if (r.offset >= shadow_len[seg])
               o.status = STAT_RANGE;
            else if (r.opcode == OP_LOAD)
               o.word_out = shadow_words[seg*SEGW + int'(r.offset)];
            else begin
               shadow_words[seg*SEGW + int'(r.offset)] = r.word_in;
               if (seg == 0) seg0_written[r.offset] = 1'b1;
            end
         end
         OP_MAP: begin
            id = -1;
            // size check first, then the free stack, then a fresh id
            if (r.map_size > SEGW)
               o.status = STAT_SIZE;
            else if (free_top > 0) begin
               free_top--;
               id = int'(free_ids[free_top]);
            end else if (fresh_id < NSEG) begin
               id = fresh_id;
               fresh_id++;
            end else
               o.status = STAT_NO_ID;
            if (id >= 0) begin
               base = id * SEGW;
               for (n = 0; n < int'(r.map_size); n++) shadow_words[base + n] = '0;
               shadow_len[id]   = r.map_size;
               shadow_live[id]  = 1'b1;
               o.new_segment_id = SEG_ID_W'(id);
            end
         end
         OP_UNMAP: begin
            if (seg == 0)
               o.status = STAT_UNMAP_ZERO;
            else if (!shadow_live[seg])
               o.status = STAT_UNMAPPED;
            else if (free_top < NSEG) begin
               shadow_live[seg]   = 1'b0;
               shadow_len[seg]    = '0;
               free_ids[free_top] = r.segment_id;
               free_top++;
            end
         end
         OP_PROG: begin
            // load program of segment zero onto itself is a no-op
            if (!shadow_live[seg])
               o.status = STAT_UNMAPPED;
            else if (seg != 0) begin
               copy_len = clamp_len(shadow_len[seg]);
               base     = seg * SEGW;
               for (n = 0; n < SEGW; n++) seg0_written[n] = (n < int'(copy_len));
               for (n = 0; n < int'(copy_len); n++) shadow_words[n] = shadow_words[base + n];
               shadow_len[0] = copy_len;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      failures++;
      if (failures <= MAX_NOTES)
         $display("%0t ns: %s: expected %0h, got %0h", $time, what, want, got);
   endtask

   always @(negedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0)
            note_mismatch("result with nothing pending, status", '0, rsp_item.status);
         else begin
            want = pending_rsp.pop_front();
            if (rsp_item.word_out !== want.word_out)
               note_mismatch("word_out", want.word_out, rsp_item.word_out);
            if (rsp_item.new_segment_id !== want.new_segment_id)
               note_mismatch("new_segment_id", want.new_segment_id, rsp_item.new_segment_id);
            if (rsp_item.status !== want.status)
               note_mismatch("status", want.status, rsp_item.status);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------
   // Presents one item, holds it until accepted, then books its result.
   // A typed row books the typed-in result; the shadow still advances.
   task automatic send_item(input req_type r, input bit typed, input rsp_type answer);
      rsp_type predicted;
      // never read a word of segment zero that holds no defined data
      if (r.opcode == OP_LOAD && r.segment_id == 0 && r.offset < shadow_len[0] &&
          !seg0_written[r.offset])
         r.opcode = OP_STORE;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_mem_op(r);
      pending_rsp.push_back(typed ? answer : predicted);
   endtask

   // Drops valid and waits until every booked result has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_program_length(input logic [LEN_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      // length of segment zero follows the register at once, saturated
      shadow_len[0] = clamp_len(value);
   endtask

   task automatic add_row(input logic [OP_W-1:0] op, input int seg, input int off,
                          input logic [WORD_W-1:0] word, input int size, input bit typed,
                          input logic [WORD_W-1:0] exp_word, input int exp_id,
                          input logic [STAT_W-1:0] exp_stat);
      row_type row;
      row.item.opcode          = op;
      row.item.segment_id      = SEG_ID_W'(seg);
      row.item.offset          = OFF_W'(off);
      row.item.word_in         = word;
      row.item.map_size        = LEN_W'(size);
      row.typed                = typed;
      row.answer.word_out       = exp_word;
      row.answer.new_segment_id = SEG_ID_W'(exp_id);
      row.answer.status         = exp_stat;
      plan.push_back(row);
   endtask

   // Random item, mostly well formed against the current shadow state.
   function automatic req_type draw_item(input mix_type mix);
      req_type r;
      int      live_ids [$];
      int      pick;
      int      s;
      int      c_load, c_store, c_map, c_unmap, c_prog, c_bad;
      case (mix)
         MIX_MAP_HEAVY:   begin c_load = 15; c_store = 35; c_map = 80;
                                c_unmap = 85; c_prog = 88; c_bad = 90; end
         MIX_UNMAP_HEAVY: begin c_load = 25; c_store = 50; c_map = 60;
                                c_unmap = 85; c_prog = 90; c_bad = 92; end
         default:         begin c_load = 30; c_store = 60; c_map = 72;
                                c_unmap = 82; c_prog = 86; c_bad = 89; end
      endcase
      for (s = 1; s < NSEG; s++) if (shadow_live[s]) live_ids.push_back(s);

      r = '0;
      case ($urandom_range(9))
         0:       r.word_in = '0;
         1:       r.word_in = '1;
         default: r.word_in = $urandom;
      endcase
      pick = $urandom_range(99);

      if (pick < c_store) begin
         r.opcode = (pick < c_load) ? OP_LOAD : OP_STORE;
         s = (live_ids.size() == 0 || $urandom_range(4) == 0) ? 0 :
             live_ids[$urandom_range(live_ids.size() - 1)];
         if ($urandom_range(9) == 0) s = $urandom_range(NSEG - 1);
         r.segment_id = SEG_ID_W'(s);
         if (shadow_len[s] > 0 && $urandom_range(9) != 0)
            r.offset = OFF_W'($urandom_range(int'(shadow_len[s]) - 1));
         else
            r.offset = OFF_W'($urandom_range(SEGW - 1));
      end else if (pick < c_map) begin
         r.opcode = OP_MAP;
         r.segment_id = SEG_ID_W'($urandom_range(NSEG - 1));
         pick = $urandom_range(99);
         // mostly small segments; a few at full size keep the run short
         if (pick < 65)      r.map_size = LEN_W'($urandom_range(16));
         else if (pick < 88) r.map_size = LEN_W'($urandom_range(200, 17));
         else if (pick < 94) r.map_size = LEN_W'($urandom_range(SEGW, 1000));
         else                r.map_size = LEN_W'($urandom_range(2047, SEGW + 1));
      end else if (pick < c_prog) begin
         r.opcode = (pick < c_unmap) ? OP_UNMAP : OP_PROG;
         if (live_ids.size() != 0 && $urandom_range(5) != 0)
            r.segment_id = SEG_ID_W'(live_ids[$urandom_range(live_ids.size() - 1)]);
         else
            r.segment_id = SEG_ID_W'($urandom_range(NSEG - 1));
         r.offset = OFF_W'($urandom_range(SEGW - 1));
      end else begin
         // unused opcodes, or plain noise over every field
         r.opcode     = (pick < c_bad) ? OP_W'($urandom_range(OP_BAD_HI, OP_BAD_LO)) :
                                         OP_W'($urandom_range(7));
         r.segment_id = SEG_ID_W'($urandom_range(NSEG - 1));
         r.offset     = OFF_W'($urandom_range(SEGW - 1));
         r.map_size   = LEN_W'($urandom_range(2047));
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [LEN_W-1:0] cfg_plan [RANDOM_PHASES];
      mix_type          mix_plan [RANDOM_PHASES];
      int               p;
      int               k;
      shadow_reset();

      // directed table; program_length still at its reset value of zero
      add_row(OP_LOAD,   0,    0, '0,    0, 1, '0, 0, STAT_RANGE);
      add_row(OP_STORE,  0, 1023, '1,    0, 1, '0, 0, STAT_RANGE);
      add_row(OP_LOAD,   5,    0, '0,    0, 1, '0, 0, STAT_UNMAPPED);
      add_row(OP_STORE, 63, 1023, '1,    0, 1, '0, 0, STAT_UNMAPPED);
      add_row(OP_UNMAP,  0,    0, '0,    0, 1, '0, 0, STAT_UNMAP_ZERO);
      add_row(OP_UNMAP,  9,    0, '0,    0, 1, '0, 0, STAT_UNMAPPED);
      add_row(OP_PROG,   7,    0, '0,    0, 1, '0, 0, STAT_UNMAPPED);
      add_row(OP_PROG,   0,    0, '0,    0, 1, '0, 0, STAT_OK);      // self load
      add_row(OP_MAP,    0,    0, '0, 1025, 1, '0, 0, STAT_SIZE);
      add_row(OP_MAP,   63, 1023, '1, 2047, 1, '0, 0, STAT_SIZE);
      add_row(OP_BAD_LO, 63, 1023, '1, 2047, 1, '0, 0, STAT_OK);
      add_row(OP_BAD_HI, 63, 1023, '1, 2047, 1, '0, 0, STAT_OK);
      add_row(OP_MAP,    0,    0, '0,    1, 1, '0, 1, STAT_OK);      // first fresh id
      add_row(OP_MAP,    0,    0, '0, 1024, 1, '0, 2, STAT_OK);
      add_row(OP_STORE,  2, 1023, '1,    0, 1, '0, 0, STAT_OK);
      add_row(OP_LOAD,   2, 1023, '0,    0, 0, '0, 0, STAT_OK);
      add_row(OP_LOAD,   2,    0, '0,    0, 0, '0, 0, STAT_OK);
      add_row(OP_LOAD,   1,    1, '0,    0, 1, '0, 0, STAT_RANGE);
      add_row(OP_STORE,  1,    0, 32'h5a5a_5a5a, 0, 0, '0, 0, STAT_OK);
      add_row(OP_PROG,   2,    0, '0,    0, 1, '0, 0, STAT_OK);      // full-size copy
      add_row(OP_LOAD,   0, 1023, '0,    0, 0, '0, 0, STAT_OK);
      add_row(OP_UNMAP,  2,    0, '0,    0, 1, '0, 0, STAT_OK);
      add_row(OP_LOAD,   2,    0, '0,    0, 1, '0, 0, STAT_UNMAPPED);
      add_row(OP_MAP,    0,    0, '0,    0, 1, '0, 2, STAT_OK);      // recycled id
      add_row(OP_STORE,  2,    0, '1,    0, 1, '0, 0, STAT_RANGE);

      // settings per random phase, extremes among them
      cfg_plan[0] = LEN_W'($urandom_range(64, 1));
      cfg_plan[1] = LEN_W'(SEGW);
      cfg_plan[2] = '0;
      cfg_plan[3] = '1;                                  // saturates to SEGW
      cfg_plan[4] = LEN_W'($urandom_range(SEGW - 1, 2));
      cfg_plan[5] = 11'd1;
      mix_plan    = '{MIX_BALANCED, MIX_MAP_HEAVY, MIX_BALANCED,
                      MIX_UNMAP_HEAVY, MIX_MAP_HEAVY, MIX_BALANCED};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) send_item(plan[k].item, plan[k].typed, plan[k].answer);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         set_program_length(cfg_plan[p]);
         calm = (p == 2);                                // one phase with no idling
         for (k = 0; k < PHASE_ITEMS; k++) send_item(draw_item(mix_plan[p]), 1'b0, '0);
      end
      calm = 1'b0;

      wait_drained();
      if (failures == 0)
         $display("segmented_memory_with_id_recycling_core verification clean");
      else
         $display("segmented_memory_with_id_recycling_core verification failed");
      $finish;
   end

   // Run limit: far above the slowest expected run, stalls included.
   initial begin
      #4ms;
      $display("segmented_memory_with_id_recycling_core verification failed");
      $finish;
   end

endmodule
